[hdl/assert_macros.svh]
// Assertion macros used by the checker slp_chk.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante holds -> cons holds in the next cycle
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/slp_pkg.sv]
// Package for the sample rate to log pitch converter: constants, tables, stage types.
// No dependencies.
`default_nettype none

package slp_pkg;

  localparam int RATE_W  = 20;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 5;
  localparam int IDX_W   = 7;
  localparam int MAG_W   = 20;
  localparam int SLOPE_W = 7;
  localparam int SCALE_W = 14;
  localparam int INT_W   = WORD_W - MAG_W;

  localparam logic [SCALE_W-1:0] SCALE_FACTOR = 14'd11185;
  localparam logic [INT_W-1:0]   POS_BIAS     = 12'd15;

  typedef struct packed {
    logic              vld;
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  frac;
  } norm_t;

  localparam logic [MAG_W-1:0] MAG_TAB [0:127] = '{
    20'h00000, 20'h02dfc, 20'h05b9e, 20'h088e6, 20'h0b5d6, 20'h0e26f, 20'h10eb3, 20'h13aa2,
    20'h1663f, 20'h1918a, 20'h1bc84, 20'h1e72e, 20'h2118b, 20'h23b9a, 20'h2655d, 20'h28ed5,
    20'h2b803, 20'h2e0e8, 20'h30985, 20'h331db, 20'h359eb, 20'h381b6, 20'h3a93d, 20'h3d081,
    20'h3f782, 20'h41e42, 20'h444c1, 20'h46b01, 20'h49101, 20'h4b6c4, 20'h4dc49, 20'h50191,
    20'h5269e, 20'h54b6f, 20'h57006, 20'h59463, 20'h5b888, 20'h5dc74, 20'h60029, 20'h623a7,
    20'h646ee, 20'h66a00, 20'h68cdd, 20'h6af86, 20'h6d1fa, 20'h6f43c, 20'h7164b, 20'h73829,
    20'h759d4, 20'h77b4f, 20'h79c9a, 20'h7bdb5, 20'h7dea1, 20'h7ff5e, 20'h81fed, 20'h8404e,
    20'h86082, 20'h88089, 20'h8a064, 20'h8c014, 20'h8df98, 20'h8fef1, 20'h91e20, 20'h93d26,
    20'h95c01, 20'h97ab4, 20'h9993e, 20'h9b79f, 20'h9d5d9, 20'h9f3ec, 20'ha11d8, 20'ha2f9d,
    20'ha4d3c, 20'ha6ab5, 20'ha8808, 20'haa537, 20'hac241, 20'hadf26, 20'hafbe7, 20'hb1885,
    20'hb3500, 20'hb5157, 20'hb6d8c, 20'hb899f, 20'hba58f, 20'hbc15e, 20'hbdd0c, 20'hbf899,
    20'hc1404, 20'hc2f50, 20'hc4a7b, 20'hc6587, 20'hc8073, 20'hc9b3f, 20'hcb5ed, 20'hcd07c,
    20'hceaec, 20'hd053f, 20'hd1f73, 20'hd398a, 20'hd5384, 20'hd6d60, 20'hd8720, 20'hda0c3,
    20'hdba4a, 20'hdd3b4, 20'hded03, 20'he0636, 20'he1f4e, 20'he384a, 20'he512c, 20'he69f3,
    20'he829f, 20'he9b31, 20'heb3a9, 20'hecc08, 20'hee44c, 20'hefc78, 20'hf148a, 20'hf2c83,
    20'hf4463, 20'hf5c2a, 20'hf73da, 20'hf8b71, 20'hfa2f0, 20'hfba57, 20'hfd1a7, 20'hfe8df
  };

  localparam logic [SLOPE_W-1:0] SLOPE_TAB [0:127] = '{
    7'h5c, 7'h5c, 7'h5b, 7'h5a, 7'h5a, 7'h59, 7'h58, 7'h58,
    7'h57, 7'h56, 7'h56, 7'h55, 7'h55, 7'h54, 7'h53, 7'h53,
    7'h52, 7'h52, 7'h51, 7'h51, 7'h50, 7'h50, 7'h4f, 7'h4f,
    7'h4e, 7'h4d, 7'h4d, 7'h4d, 7'h4c, 7'h4c, 7'h4b, 7'h4b,
    7'h4a, 7'h4a, 7'h49, 7'h49, 7'h48, 7'h48, 7'h47, 7'h47,
    7'h47, 7'h46, 7'h46, 7'h45, 7'h45, 7'h45, 7'h44, 7'h44,
    7'h43, 7'h43, 7'h43, 7'h42, 7'h42, 7'h42, 7'h41, 7'h41,
    7'h41, 7'h40, 7'h40, 7'h40, 7'h3f, 7'h3f, 7'h3f, 7'h3e,
    7'h3e, 7'h3e, 7'h3d, 7'h3d, 7'h3d, 7'h3c, 7'h3c, 7'h3c,
    7'h3b, 7'h3b, 7'h3b, 7'h3b, 7'h3a, 7'h3a, 7'h3a, 7'h39,
    7'h39, 7'h39, 7'h39, 7'h38, 7'h38, 7'h38, 7'h38, 7'h37,
    7'h37, 7'h37, 7'h37, 7'h36, 7'h36, 7'h36, 7'h36, 7'h35,
    7'h35, 7'h35, 7'h35, 7'h34, 7'h34, 7'h34, 7'h34, 7'h34,
    7'h33, 7'h33, 7'h33, 7'h33, 7'h32, 7'h32, 7'h32, 7'h32,
    7'h32, 7'h31, 7'h31, 7'h31, 7'h31, 7'h31, 7'h30, 7'h30,
    7'h30, 7'h30, 7'h30, 7'h2f, 7'h2f, 7'h2f, 7'h2f, 7'h2f
  };

endpackage

`default_nettype wire

[hdl/slp_mult.sv]
// Stage 1: scales the rate by a constant, product kept to 32 bits.
// Depends on slp_pkg.
`default_nettype none

module slp_mult import slp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [RATE_W-1:0] rate,
  output logic                   prod_vld,
  output logic [WORD_W-1:0]      prod
);

  logic [WORD_W-1:0] full;

  assign full = {{(WORD_W-RATE_W){1'b0}}, rate} * {{(WORD_W-SCALE_W){1'b0}}, SCALE_FACTOR};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod <= full;
  end

endmodule

`default_nettype wire

[hdl/slp_norm.sv]
// Stages 2 and 3: leading-one detect, then normalize and split into index and fraction.
// Depends on slp_pkg.
`default_nettype none

module slp_norm import slp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              prod_vld,
  input  wire logic [WORD_W-1:0] prod,
  output norm_t                  norm
);

  logic [POS_W-1:0]  lead;
  logic              a_vld;
  logic [POS_W-1:0]  a_pos;
  logic [WORD_W-1:0] a_prod;
  logic [WORD_W-1:0] shifted;

  // bit 0 alone counts as no leading one
  always_comb begin
    lead = '0;
    for (int i = 1; i < WORD_W; i++) begin
      if (prod[i]) begin
        lead = POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_pos  <= lead;
    a_prod <= prod;
  end

  assign shifted = a_prod << (POS_W'(WORD_W - 1) - a_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      norm.vld <= 1'b0;
    end else begin
      norm.vld <= a_vld;
    end
    norm.pos  <= a_pos;
    norm.idx  <= shifted[WORD_W-2 -: IDX_W];
    norm.frac <= shifted[WORD_W-2-IDX_W -: IDX_W];
  end

endmodule

`default_nettype wire

[hdl/slp_interp.sv]
// Stage 4: table lookup and linear interpolation into the pitch word.
// Depends on slp_pkg.
`default_nettype none

module slp_interp import slp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  norm_t             norm,
  output logic              out_vld,
  output logic [WORD_W-1:0] word
);

  logic [MAG_W-1:0]         mag;
  logic [SLOPE_W-1:0]       slope;
  logic [IDX_W+SLOPE_W-1:0] step;
  logic [INT_W-1:0]         int_part;
  logic [WORD_W-1:0]        sum;

  assign mag      = MAG_TAB[norm.idx];
  assign slope    = SLOPE_TAB[norm.idx];
  assign step     = {{SLOPE_W{1'b0}}, norm.frac} * {{IDX_W{1'b0}}, slope};
  assign int_part = INT_W'(norm.pos) - POS_BIAS;
  assign sum      = {int_part, {MAG_W{1'b0}}} + {{(WORD_W-MAG_W){1'b0}}, mag}
                  + {{(WORD_W-IDX_W-SLOPE_W){1'b0}}, step};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= norm.vld;
    end
  end

  always_ff @(posedge clk) begin
    word <= (norm.pos == '0) ? '0 : sum;
  end

endmodule

`default_nettype wire

[hdl/sample_rate_to_log_pitch.sv]
// Top level of the sample rate to log pitch converter.
// Depends on slp_pkg, slp_mult, slp_norm, slp_interp.
//
// Usage:
//   Drive sample_rate and pulse start; an item is taken at each rising edge
//   with start high and busy low. busy stays low, so one item can be taken
//   every clock cycle.
//   After an item is taken, done is high for one cycle with its pitch_word
//   (integer part of log2 from bit 20, fraction below). Results come out
//   in the order the items went in. Each item passes through multiply,
//   leading-one detect, normalize, then table lookup with interpolate and
//   add. Throughput is 1 item per cycle.
//   Rates 0 and any rate whose scaled product is 0 or 1 give 0.
//   Synchronous reset drops all items in flight; done is low after it.
//   The receiver has no hold-off: each result must be taken while done
//   is high.
`default_nettype none

module sample_rate_to_log_pitch import slp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [RATE_W-1:0] sample_rate,
  output logic                   done,
  output logic [WORD_W-1:0]      pitch_word
);

  logic              prod_vld;
  logic [WORD_W-1:0] prod;
  norm_t             norm;

  assign busy = 1'b0;

  slp_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start & ~busy),
    .rate     (sample_rate),
    .prod_vld (prod_vld),
    .prod     (prod)
  );

  slp_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .prod_vld (prod_vld),
    .prod     (prod),
    .norm     (norm)
  );

  slp_interp u_interp (
    .clk     (clk),
    .rst     (rst),
    .norm    (norm),
    .out_vld (done),
    .word    (pitch_word)
  );

endmodule

`default_nettype wire

[hdl/slp_chk.sv]
// Port-level checker for the sample rate to log pitch converter, bound to the top level.
// Depends on slp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slp_chk import slp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [RATE_W-1:0] sample_rate,
  input wire logic              done,
  input wire logic [WORD_W-1:0] pitch_word
);

  logic zero_in;

  assign zero_in = (sample_rate == '0);

  `ASSERT_IMP(a_never_busy, clk, rst, 1'b1, !busy, "busy raised")
  `ASSERT_IMP(a_done_has_item, clk, rst, done, $past(start, 4), "result with no item")
  `ASSERT_IMP(a_item_gives_done, clk, rst, start && !busy, ##4 done, "item lost")
  `ASSERT_IMP(a_zero_rate, clk, rst, done && $past(zero_in, 4), pitch_word == '0, "zero rate")
  `ASSERT_NXT(a_done_low_after_idle, clk, rst, !start [*4], !done, "spurious result")

endmodule

bind sample_rate_to_log_pitch slp_chk u_slp_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .sample_rate (sample_rate),
  .done        (done),
  .pitch_word  (pitch_word)
);

`default_nettype wire
